/* design/fault_record_table_assert.svh */
// Assertion macros for the fault record table
`ifndef FAULT_RECORD_TABLE_ASSERT_SVH
`define FAULT_RECORD_TABLE_ASSERT_SVH

// property must hold at every clock edge out of reset
`define FRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen out of reset
`define FRT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/frt_pkg.sv */
// Shared types and constants of the fault record table
`timescale 1ns / 1ps
package frt_pkg;

  localparam logic [7:0] CNT_MAX = 8'hFF;

  localparam logic [3:0] MODE_SET     = 4'd0;
  localparam logic [3:0] MODE_DEL_ONE = 4'd1;
  localparam logic [3:0] MODE_DEL_GRP = 4'd2;
  localparam logic [3:0] MODE_CLR_A   = 4'd3;
  localparam logic [3:0] MODE_CLR_L   = 4'd4;
  localparam logic [3:0] MODE_FIND_A  = 4'd5;
  localparam logic [3:0] MODE_FIND_L  = 4'd6;
  localparam logic [3:0] MODE_READ_A  = 4'd7;
  localparam logic [3:0] MODE_READ_L  = 4'd8;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  param;
    logic [7:0]  count;
    logic [31:0] stamp;
  } rec_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_BUMP,
    OP_WRITE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    logic key;
    logic code;
    logic idx;
  } cell_hit_t;

endpackage

/* design/frt_cell.sv */
// One record slot of a table row, with its own compare logic
`timescale 1ns / 1ps
module frt_cell import frt_pkg::*; #(
  parameter int IDX = 0,
  parameter int FW  = 5
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  rec_t          rec_new,
  input  rec_t          rec_nxt,
  input  logic [FW-1:0] used,
  input  logic [15:0]   key_code,
  input  logic [7:0]    key_param,
  input  logic [3:0]    entry_index,
  output rec_t          rec,
  output cell_hit_t     hit
);

  localparam logic [FW-1:0] IDX_F = FW'(IDX);
  localparam logic [6:0]    IDX_W = 7'(IDX);

  logic filled;

  always_ff @(posedge clk) begin
    case (op)
      OP_BUMP: begin
        if (rec.count != CNT_MAX) rec.count <= rec.count + 8'd1;
        rec.stamp <= rec_new.stamp;
      end
      OP_WRITE: rec <= rec_new;
      OP_SHIFT: rec <= rec_nxt;
      default: ;
    endcase
  end

  assign filled   = IDX_F < used;
  assign hit.code = filled && (rec.code == key_code);
  assign hit.key  = hit.code && (rec.param == key_param);
  assign hit.idx  = filled && ({3'b000, entry_index} == IDX_W);

endmodule

/* design/fault_record_table.sv */
// Top level of the fault record table: two rows of record cells and their sequencer
`timescale 1ns / 1ps
// Fault record table. Holds an active table and a persistent log of up to
// MAX_ENTRIES records each, every record in a cell of its own that compares
// against the broadcast key in parallel; deletion compacts the active table by
// having the removed cell and each cell above it load its upper neighbor. An item
// passes through accept, search, update and result, the search-then-update sequence
// through the cell rows; a group delete removes one record per search and
// update pass, repeating the pair until no code hit is left. A new item
// is taken while the previous result still waits in the output register.
`include "fault_record_table_assert.svh"
module fault_record_table import frt_pkg::*; #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  mode,
  input  logic [15:0] fault_code,
  input  logic [7:0]  fault_param,
  input  logic        also_log,
  input  logic [3:0]  entry_index,
  input  logic [31:0] now_ticks,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [15:0] rec_code,
  output logic [7:0]  rec_param,
  output logic [7:0]  rec_count,
  output logic [31:0] rec_time,
  output logic [4:0]  active_fill,
  output logic [4:0]  log_fill
);

  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW = $clog2(MAX_ENTRIES + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(MAX_ENTRIES);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SRCH = 4'b0010,
    S_ACT  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [3:0]  mode_q;
  logic [15:0] code_q;
  logic [7:0]  param_q;
  logic        also_q;
  logic [3:0]  idx_q;
  logic [31:0] now_q;

  logic [FW-1:0] active_used, active_used_next;
  logic [FW-1:0] log_used, log_used_next;

  rec_t      a_rec [MAX_ENTRIES];
  rec_t      l_rec [MAX_ENTRIES];
  cell_hit_t a_hit [MAX_ENTRIES];
  cell_hit_t l_hit [MAX_ENTRIES];
  cell_op_t  a_op  [MAX_ENTRIES];
  cell_op_t  l_op  [MAX_ENTRIES];
  rec_t      rec_new;

  logic [MAX_ENTRIES-1:0] a_key_q, a_code_q, a_idx_q, l_key_q, l_idx_q;

  logic        res_found, res_found_next;
  rec_t        res_rec, res_rec_next;

  function automatic logic [IW-1:0] first_set(input logic [MAX_ENTRIES-1:0] v);
    logic [IW-1:0] r;
    r = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IW'(i);
    end
    return r;
  endfunction

  assign rec_new = '{code: code_q, param: param_q, count: 8'd1, stamp: now_q};

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cells
    rec_t nxt;
    if (g == MAX_ENTRIES - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = a_rec[g+1];
    end
    frt_cell #(.IDX(g), .FW(FW)) u_a (
      .clk(clk), .op(a_op[g]), .rec_new(rec_new), .rec_nxt(nxt),
      .used(active_used), .key_code(code_q), .key_param(param_q),
      .entry_index(idx_q), .rec(a_rec[g]), .hit(a_hit[g])
    );
    frt_cell #(.IDX(g), .FW(FW)) u_l (
      .clk(clk), .op(l_op[g]), .rec_new(rec_new), .rec_nxt(rec_t'('0)),
      .used(log_used), .key_code(code_q), .key_param(param_q),
      .entry_index(idx_q), .rec(l_rec[g]), .hit(l_hit[g])
    );
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      mode_q  <= mode;
      code_q  <= fault_code;
      param_q <= fault_param;
      also_q  <= also_log;
      idx_q   <= entry_index;
      now_q   <= now_ticks;
    end
    if (state == S_SRCH) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        a_key_q[i]  <= a_hit[i].key;
        a_code_q[i] <= a_hit[i].code;
        a_idx_q[i]  <= a_hit[i].idx;
        l_key_q[i]  <= l_hit[i].key;
        l_idx_q[i]  <= l_hit[i].idx;
      end
    end
    if (state == S_ACT) begin
      res_found <= res_found_next;
      res_rec   <= res_rec_next;
    end
  end

  always_comb begin
    logic [IW-1:0]          ka, kc, kl, ks;
    logic [MAX_ENTRIES-1:0] sel_v;
    logic                   sel_log;
    logic                   room_a, room_l;
    ka = first_set(a_key_q);
    kc = first_set(a_code_q);
    kl = first_set(l_key_q);
    room_a = active_used < FILL_MAX;
    room_l = log_used < FILL_MAX;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      a_op[i] = OP_HOLD;
      l_op[i] = OP_HOLD;
    end
    active_used_next = active_used;
    log_used_next    = log_used;
    state_next       = state;
    sel_v            = '0;
    sel_log          = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SRCH;
      S_SRCH: state_next = S_ACT;
      S_ACT: begin
        state_next = S_OUT;
        unique case (mode_q) inside
          MODE_SET: begin
            if (|a_key_q) begin
              a_op[ka] = OP_BUMP;
            end else if (room_a) begin
              a_op[active_used[IW-1:0]] = OP_WRITE;
              active_used_next = active_used + 1'b1;
              if (also_q) begin
                if (|l_key_q) begin
                  l_op[kl] = OP_BUMP;
                end else if (room_l) begin
                  l_op[log_used[IW-1:0]] = OP_WRITE;
                  log_used_next = log_used + 1'b1;
                end
              end
            end
          end
          MODE_DEL_ONE, MODE_DEL_GRP: begin
            ks = (mode_q == MODE_DEL_ONE) ? ka : kc;
            if ((mode_q == MODE_DEL_ONE) ? |a_key_q : |a_code_q) begin
              for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (IW'(i) >= ks) a_op[i] = OP_SHIFT;
              end
              active_used_next = active_used - 1'b1;
              // group delete repeats the search until no code hit is left
              if (mode_q == MODE_DEL_GRP) state_next = S_SRCH;
            end
          end
          MODE_CLR_A: active_used_next = '0;
          MODE_CLR_L: log_used_next = '0;
          MODE_FIND_A: sel_v = a_key_q;
          MODE_FIND_L: begin
            sel_v   = l_key_q;
            sel_log = 1'b1;
          end
          MODE_READ_A: sel_v = a_idx_q;
          MODE_READ_L: begin
            sel_v   = l_idx_q;
            sel_log = 1'b1;
          end
          default: ;
        endcase
      end
      S_OUT: if (!out_valid || !out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    ks = first_set(sel_v);
    res_found_next = |sel_v;
    if (!res_found_next) res_rec_next = '0;
    else if (sel_log)    res_rec_next = l_rec[ks];
    else                 res_rec_next = a_rec[ks];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      active_used <= '0;
      log_used    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      active_used <= active_used_next;
      log_used    <= log_used_next;
      if (state == S_OUT && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      found       <= res_found;
      rec_code    <= res_rec.code;
      rec_param   <= res_rec.param;
      rec_count   <= res_rec.count;
      rec_time    <= res_rec.stamp;
      active_fill <= 5'(active_used);
      log_fill    <= 5'(log_used);
    end
  end

  `FRT_ASSERT(a_fill_max, (active_used <= FILL_MAX) && (log_used <= FILL_MAX), "fill over size")
  `FRT_ASSERT(a_out_src, $rose(out_valid) |-> $past(state == S_OUT), "result without update")
  `FRT_NEVER(a_grp_left, state == S_OUT && mode_q == MODE_DEL_GRP && a_code_q != '0, "group left")

endmodule
